/* src/bitmap_first_fit_allocator_macros.svh */
// Assertion helpers for the checker file.
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFFA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BFFA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/bffa_pkg.sv */
package bffa_pkg;

    localparam int CMD_W    = 1;
    localparam int LEN_W    = 13;
    localparam int BLOCK_W  = 12;
    localparam int STATUS_W = 1;
    localparam int BYTE_W   = 8;

    localparam logic [CMD_W-1:0]    CMD_ALLOC       = 1'b0;
    localparam logic [CMD_W-1:0]    CMD_FREE        = 1'b1;
    localparam logic [STATUS_W-1:0] STATUS_OK       = 1'b0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [LEN_W-1:0]   run_length;
        logic [BLOCK_W-1:0] start_block;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BLOCK_W-1:0]  first_block;
    } rsp_t;

endpackage

/* src/bffa_byte_scan.sv */
// Advance the free-run tracker across the eight blocks of one map byte.
module bffa_byte_scan #(
    parameter int TOTAL_BLOCKS = 4096,
    parameter int AW           = 9,
    parameter int BW           = 12
) (
    input  logic [AW-1:0]               byte_idx,
    input  logic [bffa_pkg::BYTE_W-1:0] data,
    input  logic [bffa_pkg::LEN_W-1:0]  len,
    input  logic [bffa_pkg::LEN_W-1:0]  run_in,
    input  logic [BW-1:0]               start_in,
    output logic [bffa_pkg::LEN_W-1:0]  run_out,
    output logic [BW-1:0]               start_out,
    output logic                        found,
    output logic [BW-1:0]               hit_start
);

    localparam logic [AW+3:0] TOTAL_X = (AW + 4)'(TOTAL_BLOCKS);

    always_comb
    begin
        logic [AW+2:0]              blk;
        logic [bffa_pkg::LEN_W-1:0] run;
        logic [BW-1:0]              start;
        logic                       hit;
        logic [BW-1:0]              hit_at;
        run    = run_in;
        start  = start_in;
        hit    = 1'b0;
        hit_at = start_in;
        for (int i = 0; i < bffa_pkg::BYTE_W; i++)
        begin
            blk = {byte_idx, 3'(i)};
            // skip blocks past the end of the map and stop at the first fit
            if (!hit && ({1'b0, blk} < TOTAL_X))
            begin
                if (!data[i])
                begin
                    if (run == '0)
                    begin
                        start = blk[BW-1:0];
                    end
                    run = run + bffa_pkg::LEN_W'(1);
                    if (run == len)
                    begin
                        hit    = 1'b1;
                        hit_at = start;
                    end
                end
                else
                begin
                    run = '0;
                end
            end
        end
        run_out   = run;
        start_out = start;
        found     = hit;
        hit_start = hit_at;
    end

endmodule

/* src/bitmap_first_fit_allocator.sv */
// First-fit block allocator over a free map of TOTAL_BLOCKS bits (1 = used), held
// as a byte-wide synchronous RAM of ceil(TOTAL_BLOCKS/8) entries. One request is
// handled at a time and each yields one response transfer. After reset the map is
// cleared by a pass over every byte with req_stall high. An allocate request scans
// the RAM one byte per cycle from block 0, stopping at the byte in which the run is
// found or at the end of the map when no run fits, and then marks the bytes the run
// spans. A free request clears the bytes its clamped range spans; a free that clears
// nothing and a zero-length allocate go straight to the response.
// The edge that raises rsp_valid also returns the allocator to idle, so the next
// request can transfer while that response is presented.
// The single RAM read port limits each pass to one byte read per cycle, and the
// mark and free passes overlap the read of one byte with the write-back of the
// previous one. A finished response sits in an output register, so the next
// request may be taken while the previous response is still stalled.
module bitmap_first_fit_allocator #(
    parameter int TOTAL_BLOCKS = 4096
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  bffa_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output bffa_pkg::rsp_t rsp
);

    localparam int MAP_BYTES = (TOTAL_BLOCKS + 7) / 8;
    localparam int AW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int CW        = $clog2(MAP_BYTES + 1);
    localparam int BW        = $clog2(TOTAL_BLOCKS);
    // wide enough for a block index and for start plus length
    localparam int SW        = ((AW + 3 > bffa_pkg::LEN_W) ? AW + 3 : bffa_pkg::LEN_W) + 1;

    localparam logic [CW-1:0] LAST_ADDR = CW'(MAP_BYTES - 1);
    localparam logic [CW-1:0] END_ADDR  = CW'(MAP_BYTES);
    localparam logic [SW-1:0] TOTAL_S   = SW'(TOTAL_BLOCKS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_RESP
    } state_t;

    state_t                     state_reg, state_next;
    logic [CW-1:0]              addr_reg, addr_next;
    logic                       pend_reg, pend_next;
    logic [AW-1:0]              pend_addr_reg, pend_addr_next;
    logic [bffa_pkg::LEN_W-1:0] len_reg, len_next;
    logic [bffa_pkg::LEN_W-1:0] run_reg, run_next;
    logic [BW-1:0]              run_start_reg, run_start_next;
    logic [SW-1:0]              lo_reg, lo_next;
    logic [SW-1:0]              end_reg, end_next;
    logic [AW-1:0]              last_reg, last_next;
    logic                       set_reg, set_next;
    bffa_pkg::rsp_t             res_reg, res_next;
    logic                       rsp_valid_reg, rsp_valid_next;
    bffa_pkg::rsp_t             rsp_reg, rsp_next;

    // free map storage, one byte per entry
    logic [bffa_pkg::BYTE_W-1:0] map_mem [MAP_BYTES];
    logic [bffa_pkg::BYTE_W-1:0] rd_data_reg;
    logic                        rd_en;
    logic                        wr_en;
    logic [AW-1:0]               rd_addr;
    logic [AW-1:0]               wr_addr;
    logic [bffa_pkg::BYTE_W-1:0] wr_data;

    logic [bffa_pkg::LEN_W-1:0]  scan_run;
    logic [BW-1:0]               scan_start;
    logic                        scan_found;
    logic [BW-1:0]               scan_hit;

    logic [bffa_pkg::BYTE_W-1:0] mask;
    logic [SW-1:0]               req_start_s;
    logic [SW-1:0]               req_end_s;
    logic [SW-1:0]               free_end_s;
    logic [SW-1:0]               free_last_s;
    logic [SW-1:0]               hit_lo_s;
    logic [SW-1:0]               hit_end_s;
    logic [SW-1:0]               hit_last_s;
    logic                        accept;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rd_addr   = addr_reg[AW-1:0];

    bffa_byte_scan #(
        .TOTAL_BLOCKS (TOTAL_BLOCKS),
        .AW           (AW),
        .BW           (BW)
    ) u_scan (
        .byte_idx  (pend_addr_reg),
        .data      (rd_data_reg),
        .len       (len_reg),
        .run_in    (run_reg),
        .start_in  (run_start_reg),
        .run_out   (scan_run),
        .start_out (scan_start),
        .found     (scan_found),
        .hit_start (scan_hit)
    );

    // Range arithmetic for a free request (clamped to the map) and for a found run.
    always_comb
    begin
        req_start_s = SW'(req.start_block);
        req_end_s   = req_start_s + SW'(req.run_length);
        free_end_s  = (req_end_s > TOTAL_S) ? TOTAL_S : req_end_s;
        free_last_s = free_end_s - SW'(1);
        hit_lo_s    = SW'(scan_hit);
        hit_end_s   = hit_lo_s + SW'(len_reg);
        hit_last_s  = hit_end_s - SW'(1);
    end

    // Bits of the byte under write-back that fall inside [lo, end).
    always_comb
    begin
        logic [SW-1:0] blk_s;
        for (int i = 0; i < bffa_pkg::BYTE_W; i++)
        begin
            blk_s   = SW'({pend_addr_reg, 3'(i)});
            mask[i] = (blk_s >= lo_reg) && (blk_s < end_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        pend_next      = 1'b0;
        pend_addr_next = rd_addr;
        len_next       = len_reg;
        run_next       = run_reg;
        run_start_next = run_start_reg;
        lo_next        = lo_reg;
        end_next       = end_reg;
        last_next      = last_reg;
        set_next       = set_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = pend_addr_reg;
        wr_data        = set_reg ? (rd_data_reg | mask) : (rd_data_reg & ~mask);

        // drop the held response once it transfers
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // zero one byte per cycle after reset
                wr_en   = 1'b1;
                wr_addr = rd_addr;
                wr_data = '0;
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + CW'(1);
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    res_next.status      = bffa_pkg::STATUS_OK;
                    res_next.first_block = '0;
                    len_next             = req.run_length;
                    if (req.command == bffa_pkg::CMD_FREE)
                    begin
                        if ((req_start_s < TOTAL_S) && (req.run_length != '0))
                        begin
                            lo_next    = req_start_s;
                            end_next   = free_end_s;
                            addr_next  = CW'(req_start_s[AW+2:3]);
                            last_next  = free_last_s[AW+2:3];
                            set_next   = 1'b0;
                            state_next = ST_MARK;
                        end
                        else
                        begin
                            state_next = ST_RESP;
                        end
                    end
                    else if (req.run_length == '0)
                    begin
                        res_next.status = bffa_pkg::STATUS_NO_SPACE;
                        state_next      = ST_RESP;
                    end
                    else
                    begin
                        run_next       = '0;
                        run_start_next = '0;
                        addr_next      = '0;
                        state_next     = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // issue the next byte read while the previous byte is examined
                if (addr_reg != END_ADDR)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    addr_next = addr_reg + CW'(1);
                end
                if (pend_reg)
                begin
                    run_next       = scan_run;
                    run_start_next = scan_start;
                    if (scan_found)
                    begin
                        lo_next              = hit_lo_s;
                        end_next             = hit_end_s;
                        addr_next            = CW'(hit_lo_s[AW+2:3]);
                        last_next            = hit_last_s[AW+2:3];
                        set_next             = 1'b1;
                        res_next.first_block = bffa_pkg::BLOCK_W'(scan_hit);
                        pend_next            = 1'b0;
                        state_next           = ST_MARK;
                    end
                end
                else if (addr_reg == END_ADDR)
                begin
                    res_next.status = bffa_pkg::STATUS_NO_SPACE;
                    state_next      = ST_RESP;
                end
            end

            ST_MARK:
            begin
                // read byte k+1 while byte k is written back; addresses never collide
                if (addr_reg <= CW'(last_reg))
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    addr_next = addr_reg + CW'(1);
                end
                if (pend_reg)
                begin
                    wr_en = 1'b1;
                end
                else if (addr_reg > CW'(last_reg))
                begin
                    state_next = ST_RESP;
                end
            end

            ST_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        len_reg       <= len_next;
        run_reg       <= run_next;
        run_start_reg <= run_start_next;
        lo_reg        <= lo_next;
        end_reg       <= end_next;
        last_reg      <= last_next;
        set_reg       <= set_next;
        res_reg       <= res_next;
        rsp_reg       <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

endmodule

/* src/bffa_checker.sv */
`include "bitmap_first_fit_allocator_macros.svh"

module bffa_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input bffa_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input bffa_pkg::rsp_t rsp
);

    // one request in flight: stall right after a request transfer
    `BFFA_ASSERT_NXT(a_one_at_a_time, clk, rst_n, req_valid && !req_stall, req_stall, "request taken while busy")

    // a response only appears out of a busy cycle
    `BFFA_ASSERT_IMP(a_rsp_from_busy, clk, rst_n, $rose(rsp_valid), $past(req_stall), "response without work")

    // no-space responses carry a zero start block
    `BFFA_ASSERT_IMP(a_fail_zero, clk, rst_n, rsp_valid && (rsp.status == bffa_pkg::STATUS_NO_SPACE), rsp.first_block == '0, "failed allocate with nonzero block")

    // hold a stalled response
    `BFFA_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response changed")

endmodule

bind bitmap_first_fit_allocator bffa_checker u_bffa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

/* bench/tb_top.sv */
module tb_top;

    localparam int MAP_BLOCKS  = 4096;
    localparam int RANDOM_REQS = 750;
    localparam int MAX_WAIT    = 13;
    // Slowest request: full failed scan plus marking a whole map, plus both idle gaps.
    // Take that several times over for every request, and add the clearing pass.
    localparam int CYCLE_LIMIT = 4000000;
    // Cycles to watch for stray responses once nothing is outstanding.
    localparam int TAIL_CYCLES = 1100;

    typedef struct {
        int first;
        int len;
    } live_run_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic           req_valid;
    logic           req_stall;
    bffa_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_stall;
    bffa_pkg::rsp_t rsp;

    // Requests waiting to be driven, in the order they were generated.
    bffa_pkg::req_t pending_req[$];
    // Responses the allocator owes us, oldest first.
    bffa_pkg::rsp_t owed_rsp[$];

    // Block map as the allocator should see it (1 = used), advanced per transfer.
    logic [MAP_BLOCKS-1:0] used_map;
    // Separate map used only while generating, to know which runs are live.
    logic [MAP_BLOCKS-1:0] plan_map;
    live_run_t live_runs[$];

    bit err_seen = 1'b0;
    int cycle_count = 0;

    bitmap_first_fit_allocator #(
        .TOTAL_BLOCKS(MAP_BLOCKS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Apply one request to a block map and return the response it earns.
    // Allocate: first run of free blocks from block 0 upward. Free: clear the range,
    // clamped at the last block of the map.
    function automatic bffa_pkg::rsp_t first_fit_step(inout logic [MAP_BLOCKS-1:0] map,
                                                      input bffa_pkg::req_t r);
        bffa_pkg::rsp_t res;
        int   first;
        int   len;
        int   run;
        int   run_first;
        int   b;
        bit   found;
        res       = '0;
        first     = int'(r.start_block);
        len       = int'(r.run_length);
        run       = 0;
        run_first = 0;
        found     = 1'b0;
        if (r.command == bffa_pkg::CMD_FREE)
        begin
            for (b = first; b < first + len && b < MAP_BLOCKS; b++)
                map[b] = 1'b0;
            res.status = bffa_pkg::STATUS_OK;
        end
        else
        begin
            // A zero-length allocate never finds a run.
            if (len != 0)
            begin
                for (b = 0; b < MAP_BLOCKS && !found; b++)
                begin
                    if (!map[b])
                    begin
                        if (run == 0)
                            run_first = b;
                        run++;
                        if (run == len)
                            found = 1'b1;
                    end
                    else
                        run = 0;
                end
            end
            if (found)
            begin
                for (b = run_first; b < run_first + len; b++)
                    map[b] = 1'b1;
                res.status      = bffa_pkg::STATUS_OK;
                res.first_block = run_first[bffa_pkg::BLOCK_W-1:0];
            end
            else
                res.status = bffa_pkg::STATUS_NO_SPACE;
        end
        return res;
    endfunction

    // Idle cycles before the next item; a calm stretch has none.
    function automatic int draw_wait(input bit calm);
        if (calm)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Mostly short runs, some long ones, and now and then anything the field holds.
    function automatic int pick_length();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 2)
            return 0;
        if (sel < 70)
            return $urandom_range(1, 16);
        if (sel < 90)
            return $urandom_range(17, 256);
        if (sel < 97)
            return $urandom_range(257, 1024);
        return $urandom_range(0, 8191);
    endfunction

    // Queue one request and track on the planning map which runs it leaves live.
    task automatic queue_request(input logic [bffa_pkg::CMD_W-1:0] cmd, input int len,
                                 input int start);
        bffa_pkg::req_t r;
        bffa_pkg::rsp_t res;
        live_run_t      lr;
        r.command     = cmd;
        r.run_length  = len[bffa_pkg::LEN_W-1:0];
        r.start_block = start[bffa_pkg::BLOCK_W-1:0];
        res = first_fit_step(plan_map, r);
        if (cmd == bffa_pkg::CMD_ALLOC && res.status == bffa_pkg::STATUS_OK)
        begin
            lr.first = int'(res.first_block);
            lr.len   = len;
            live_runs.push_back(lr);
        end
        pending_req.push_back(r);
    endtask

    // Driver: present the next pending request after its idle gap. Hold valid and
    // payload while stalled; on a transfer, predict its response right away.
    int  req_gap;
    int  req_sent;
    bit  req_calm;

    always @(posedge clk or negedge rst_n)
    begin : drive_req
        int nw;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            req_gap   <= 0;
            req_sent  = 0;
            req_calm  = 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                owed_rsp.push_back(first_fit_step(used_map, req));
                req_sent++;
                // Switch between idling and back-to-back stretches now and then.
                if (req_sent % 40 == 0)
                    req_calm = ($urandom_range(0, 3) == 0);
                nw = draw_wait(req_calm);
                if (nw == 0 && pending_req.size() > 0)
                    req <= pending_req.pop_front();
                else
                begin
                    req_valid <= 1'b0;
                    req_gap   <= nw;
                end
            end
            else if (!req_valid)
            begin
                if (req_gap > 0)
                    req_gap <= req_gap - 1;
                else if (pending_req.size() > 0)
                begin
                    req       <= pending_req.pop_front();
                    req_valid <= 1'b1;
                end
            end
        end
    end

    // Monitor: check each response transfer against the oldest owed response, then
    // stall for a drawn number of cycles before taking the next one.
    int rsp_hold;
    int rsp_seen;
    bit rsp_calm;

    always @(posedge clk or negedge rst_n)
    begin : watch_rsp
        bffa_pkg::rsp_t want;
        int             nw;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rsp_hold  <= 0;
            rsp_seen  = 0;
            rsp_calm  = 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (owed_rsp.size() == 0)
                begin
                    $error("response transfer with no request outstanding: %s %0d %s %0d",
                           "status", rsp.status, "first_block", rsp.first_block);
                    err_seen = 1'b1;
                end
                else
                begin
                    want = owed_rsp.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, rsp.status);
                        err_seen = 1'b1;
                    end
                    if (rsp.first_block !== want.first_block)
                    begin
                        $error("first_block mismatch: expected %0d, actual %0d",
                               want.first_block, rsp.first_block);
                        err_seen = 1'b1;
                    end
                end
                rsp_seen++;
                if (rsp_seen % 50 == 0)
                    rsp_calm = ($urandom_range(0, 3) == 0);
                nw = draw_wait(rsp_calm);
                rsp_hold  <= nw;
                rsp_stall <= (nw != 0);
            end
            else if (rsp_hold > 1)
                rsp_hold <= rsp_hold - 1;
            else if (rsp_hold == 1)
            begin
                rsp_hold  <= 0;
                rsp_stall <= 1'b0;
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int        i;
        int        pick;
        int        idx;
        live_run_t lr;

        used_map = '0;
        plan_map = '0;

        // Directed part: edges of the map and every special case.
        queue_request(bffa_pkg::CMD_ALLOC, 0, 0);       // zero-length allocate: no space
        queue_request(bffa_pkg::CMD_ALLOC, 1, 0);       // block 0
        queue_request(bffa_pkg::CMD_ALLOC, 7, 0);       // rest of byte 0
        queue_request(bffa_pkg::CMD_ALLOC, 8, 0);       // exactly byte 1
        queue_request(bffa_pkg::CMD_FREE, 7, 1);
        queue_request(bffa_pkg::CMD_ALLOC, 3, 4095);    // start is ignored on allocate
        queue_request(bffa_pkg::CMD_FREE, 4096, 0);     // clear the whole map
        queue_request(bffa_pkg::CMD_ALLOC, 4096, 0);    // whole map in one run
        queue_request(bffa_pkg::CMD_ALLOC, 1, 0);       // map full: no space
        queue_request(bffa_pkg::CMD_FREE, 1, 4095);
        queue_request(bffa_pkg::CMD_ALLOC, 1, 0);       // lands on the last block
        queue_request(bffa_pkg::CMD_FREE, 8191, 4000);  // range runs past the end: clamp
        queue_request(bffa_pkg::CMD_ALLOC, 97, 0);      // one block too long for the hole
        queue_request(bffa_pkg::CMD_ALLOC, 96, 0);      // fills the hole exactly
        queue_request(bffa_pkg::CMD_FREE, 0, 100);      // zero-length free
        queue_request(bffa_pkg::CMD_ALLOC, 1, 0);       // still full
        queue_request(bffa_pkg::CMD_FREE, 8191, 0);
        queue_request(bffa_pkg::CMD_ALLOC, 4097, 0);    // longer than the map
        queue_request(bffa_pkg::CMD_ALLOC, 8191, 4095); // largest length the field holds
        queue_request(bffa_pkg::CMD_FREE, 4096, 2048);  // free blocks that are already free
        queue_request(bffa_pkg::CMD_ALLOC, 4095, 0);
        queue_request(bffa_pkg::CMD_ALLOC, 2, 0);       // only one block left: no space
        queue_request(bffa_pkg::CMD_ALLOC, 1, 0);
        queue_request(bffa_pkg::CMD_FREE, 4096, 0);
        live_runs.delete();

        // Random part: allocate, then mostly give back runs that are live; the rest
        // are stray frees over random ranges.
        for (i = 0; i < RANDOM_REQS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 52)
                queue_request(bffa_pkg::CMD_ALLOC, pick_length(), $urandom_range(0, 4095));
            else if (pick < 88 && live_runs.size() > 0)
            begin
                idx = $urandom_range(0, live_runs.size() - 1);
                lr  = live_runs[idx];
                live_runs.delete(idx);
                queue_request(bffa_pkg::CMD_FREE, lr.len, lr.first);
            end
            else
                queue_request(bffa_pkg::CMD_FREE, pick_length(), $urandom_range(0, 4095));
        end

        // Hold reset at the start, then release it once for good.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: every request sent and every owed response seen.
        @(negedge clk);
        while (pending_req.size() > 0 || req_valid || owed_rsp.size() > 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (!err_seen)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/bffa_pkg.sv
src/bffa_byte_scan.sv
src/bitmap_first_fit_allocator.sv
src/bffa_checker.sv
bench/tb_top.sv
